// ===== rtl/scwb_pkg.sv =====
`default_nettype none
package scwb_pkg;

   localparam logic [31:0] QNAN_BITS = 32'h7FC0_0000;
   localparam int          ADDR_W    = 3;
   localparam int          STAGES    = 8;

   typedef enum logic [0:0] {
      REG_SCALE_SHIFT   = 1'b0,
      REG_NUMBER_FORMAT = 1'b1
   } reg_idx_type;

   typedef enum logic {
      FMT_FLOAT = 1'b0,
      FMT_INT   = 1'b1
   } fmt_type;

   typedef struct packed {
      logic [3:0] scale_shift;
      fmt_type    number_format;
   } cfg_type;

   // value = w * 2^(x - 153), before rounding to binary32
   typedef struct packed {
      logic               nan;
      logic               inf;
      logic               sgn;
      logic signed [10:0] x;
      logic [27:0]        w;
   } unp_type;

   typedef struct packed {
      logic        last;
      logic [31:0] mw;
      logic [31:0] t1;
      logic [31:0] mo;
      logic [31:0] a;
      unp_type     u;
      logic [31:0] ival;
   } pl_type;

   // multiply by 2^j, no rounding yet
   function automatic unp_type fp_scale_pre(input logic [31:0] f, input logic signed [5:0] j);
      unp_type            u;
      logic [7:0]         e;
      logic signed [10:0] ee;
      e      = f[30:23];
      ee     = {3'b000, (e == 8'd0) ? 8'd1 : e};
      u.nan  = (e == 8'hFF) && (f[22:0] != 23'd0);
      u.inf  = (e == 8'hFF) && (f[22:0] == 23'd0);
      u.sgn  = f[31];
      u.x    = ee + {{5{j[5]}}, j};
      u.w    = {1'b0, (e != 8'd0), f[22:0], 3'b000};
      return u;
   endfunction

   // align and add with guard, round and sticky bits
   function automatic unp_type fp_add_pre(input logic [31:0] a, input logic [31:0] b,
                                          input logic sub_b);
      unp_type     u;
      logic [31:0] bb;
      logic [31:0] big;
      logic [31:0] sml;
      logic        swap;
      logic        an;
      logic        ai;
      logic        bn;
      logic        bi;
      logic        eff_sub;
      logic [7:0]  eb;
      logic [7:0]  es;
      logic [8:0]  dd;
      logic [4:0]  dcl;
      logic [53:0] sh;
      logic [26:0] ws;
      logic [27:0] wa;
      bb      = {b[31] ^ sub_b, b[30:0]};
      an      = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
      ai      = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
      bn      = (bb[30:23] == 8'hFF) && (bb[22:0] != 23'd0);
      bi      = (bb[30:23] == 8'hFF) && (bb[22:0] == 23'd0);
      swap    = bb[30:0] > a[30:0];
      big     = swap ? bb : a;
      sml     = swap ? a : bb;
      eb      = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
      es      = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
      dd      = {1'b0, eb} - {1'b0, es};
      dcl     = (dd > 9'd31) ? 5'd31 : dd[4:0];
      sh      = {(sml[30:23] != 8'd0), sml[22:0], 3'b000, 27'd0} >> dcl;
      ws      = sh[53:27] | {26'd0, |sh[26:0]};
      wa      = {1'b0, (big[30:23] != 8'd0), big[22:0], 3'b000};
      eff_sub = big[31] ^ sml[31];
      u.w     = eff_sub ? (wa - {1'b0, ws}) : (wa + {1'b0, ws});
      u.x     = {3'b000, eb};
      u.sgn   = (eff_sub && (u.w == 28'd0)) ? 1'b0 : big[31];
      u.nan   = an | bn | (ai & bi & (a[31] != bb[31]));
      u.inf   = !u.nan && (ai | bi);
      if (u.inf) begin
         u.sgn = ai ? a[31] : bb[31];
      end
      return u;
   endfunction

   // normalise, round to nearest even, pack (subnormals kept)
   function automatic logic [31:0] fp_round_pack(input unp_type u);
      logic [4:0]         p;
      logic [4:0]         s5;
      logic signed [11:0] lsb;
      logic signed [11:0] alt;
      logic signed [11:0] nl;
      logic signed [11:0] ee;
      logic signed [11:0] xs;
      logic [31:0]        ext;
      logic [31:0]        lowm;
      logic [31:0]        half;
      logic [31:0]        low;
      logic [24:0]        m;
      logic               g;
      logic               st;
      logic [31:0]        r;
      p = 5'd0;
      for (int i = 0; i < 28; i++) begin
         if (u.w[i]) begin
            p = 5'(i);
         end
      end
      xs  = {u.x[10], u.x};
      lsb = {7'd0, p} - 12'sd23;
      alt = 12'sd4 - xs;
      if (alt > lsb) begin
         lsb = alt;
      end
      ext = {4'd0, u.w};
      m   = 25'd0;
      g   = 1'b0;
      st  = 1'b0;
      if (lsb > 12'sd28) begin
         st = 1'b1;
      end else if (lsb >= 12'sd0) begin
         s5   = lsb[4:0];
         m    = 25'(ext >> s5);
         lowm = (32'd1 << s5) - 32'd1;
         half = (s5 != 5'd0) ? (32'd1 << (s5 - 5'd1)) : 32'd0;
         low  = ext & lowm;
         g    = |(low & half);
         st   = |(low & ~half);
      end else begin
         nl = 12'sd0 - lsb;
         s5 = nl[4:0];
         m  = 25'(ext << s5);
      end
      m = m + {24'd0, g & (st | m[0])};
      if (m[24]) begin
         m   = m >> 1;
         lsb = lsb + 12'sd1;
      end
      ee = lsb + xs - 12'sd3;
      if (u.nan) begin
         r = QNAN_BITS;
      end else if (u.inf) begin
         r = {u.sgn, 8'hFF, 23'd0};
      end else if (u.w == 28'd0) begin
         r = {u.sgn, 31'd0};
      end else if (!m[23]) begin
         r = {u.sgn, 8'd0, m[22:0]};
      end else if (ee >= 12'sd255) begin
         r = {u.sgn, 8'hFF, 23'd0};
      end else begin
         r = {u.sgn, ee[7:0], m[22:0]};
      end
      return r;
   endfunction

   // |t| rounded half away from zero, for |t| < 2^23
   function automatic logic [23:0] fp_rnd_mag(input logic [31:0] t);
      logic [7:0]  e;
      logic [7:0]  sh8;
      logic [4:0]  sh;
      logic [23:0] m;
      logic [23:0] mag;
      e   = t[30:23];
      m   = {(e != 8'd0), t[22:0]};
      sh8 = 8'd150 - e;
      sh  = sh8[4:0];
      mag = 24'd0;
      if (e >= 8'd126 && e < 8'd150) begin
         mag = (m >> sh) + {23'd0, m[sh - 5'd1]};
      end
      return mag;
   endfunction

   function automatic unp_type fp_int_round_pre(input logic [31:0] t);
      unp_type u;
      if (t[30:23] >= 8'd150) begin
         u = fp_scale_pre(t, 6'sd0);
      end else begin
         u.nan = 1'b0;
         u.inf = 1'b0;
         u.sgn = t[31];
         u.x   = 11'sd150;
         u.w   = {1'b0, fp_rnd_mag(t), 3'b000};
      end
      return u;
   endfunction

   // rounded value as int32, saturated; NaN gives zero
   function automatic logic [31:0] fp_int_value(input logic [31:0] t);
      logic [7:0]  e;
      logic [7:0]  d8;
      logic [30:0] mag;
      logic [31:0] v;
      e   = t[30:23];
      d8  = e - 8'd150;
      mag = {7'd0, fp_rnd_mag(t)};
      if (e >= 8'd150) begin
         mag = {7'd0, 1'b1, t[22:0]} << d8[2:0];
      end
      v = t[31] ? (32'd0 - {1'b0, mag}) : {1'b0, mag};
      if (e == 8'hFF && t[22:0] != 23'd0) begin
         v = 32'd0;
      end else if (e >= 8'd158) begin
         v = t[31] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end
      return v;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/scwb_csr.sv =====
`default_nettype none
module scwb_csr (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        psel,
   input  wire logic                        penable,
   input  wire logic                        pwrite,
   input  wire logic [scwb_pkg::ADDR_W-1:0] paddr,
   input  wire logic [31:0]                 pwdata,
   output logic [31:0]                      prdata,
   output logic                             pready,
   output scwb_pkg::cfg_type                cfg
);
   import scwb_pkg::*;

   cfg_type     cfg_ff;
   reg_idx_type idx;
   logic        wr;

   assign pready = 1'b1;
   assign idx    = reg_idx_type'(paddr[2]);
   assign wr     = psel & penable & pwrite & pready;
   assign cfg    = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.scale_shift   <= 4'd5;
         cfg_ff.number_format <= FMT_FLOAT;
      end else if (wr) begin
         unique case (idx)
            REG_SCALE_SHIFT:   cfg_ff.scale_shift   <= pwdata[3:0];
            REG_NUMBER_FORMAT: cfg_ff.number_format <= fmt_type'(pwdata[0]);
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_SCALE_SHIFT:   prdata = {28'd0, cfg_ff.scale_shift};
         REG_NUMBER_FORMAT: prdata = {31'd0, cfg_ff.number_format};
      endcase
   end

endmodule
`default_nettype wire

// ===== rtl/single_precision_compensated_writeback.sv =====
`default_nettype none
// Channel   Direction  Handshake              Beat contents
// req_      in         req_valid/req_ready    main_word, buffer_word, last_in
// rsp_      out        rsp_valid/rsp_ready    main_out, buffer_out, last_out
// (APB)     in         psel/penable, pready   scale_shift @0x0, number_format @0x4
//
// An accepted request beat passes through every stage to its response beat;
// throughput is one beat per cycle while rsp_ready does not stall the output,
// set by the 8-stage float pipeline: scale-down+round | add/int-round prep |
//   round | sub | round | sub | round | scale-up+round.
// Reset (synchronous, high) clears stage valids and restores the registers.
// Each stage holds only when it is full and the stage after it holds, so
// bubbles are squeezed out and a request is taken while a response waits.
module single_precision_compensated_writeback (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire logic [31:0]                 req_main_word,
   input  wire logic [31:0]                 req_buffer_word,
   input  wire logic                        req_last_in,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic [31:0]                      rsp_main_out,
   output logic [31:0]                      rsp_buffer_out,
   output logic                             rsp_last_out,
   input  wire logic                        psel,
   input  wire logic                        penable,
   input  wire logic                        pwrite,
   input  wire logic [scwb_pkg::ADDR_W-1:0] paddr,
   input  wire logic [31:0]                 pwdata,
   output logic [31:0]                      prdata,
   output logic                             pready
);
   import scwb_pkg::*;

   cfg_type             cfg;
   pl_type              pipe_ff [STAGES];
   pl_type              pipe_in [STAGES];
   logic [STAGES-1:0]   valid_ff;
   logic [STAGES-1:0]   valid_in;
   logic [STAGES-1:0]   en;
   logic                fmt_int;
   logic signed [5:0]   k_s;

   scwb_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   assign fmt_int = (cfg.number_format == FMT_INT);
   assign k_s     = {2'b00, cfg.scale_shift};

   // Advance a stage when it is empty or the next one advances.
   always_comb begin
      en[STAGES-1] = !valid_ff[STAGES-1] || rsp_ready;
      for (int i = STAGES - 2; i >= 0; i--) begin
         en[i] = !valid_ff[i] || en[i+1];
      end
      valid_in[0] = en[0] ? req_valid : valid_ff[0];
      for (int i = 1; i < STAGES; i++) begin
         valid_in[i] = en[i] ? valid_ff[i-1] : valid_ff[i];
      end
   end

   assign req_ready = en[0];

   always_comb begin
      // Scale the buffer value down: t1 = buf * 2^-k, rounded.
      pipe_in[0]      = '0;
      pipe_in[0].last = req_last_in;
      pipe_in[0].mw   = req_main_word;
      pipe_in[0].t1   = fp_round_pack(fp_scale_pre(req_buffer_word, 6'sd0 - k_s));

      // Float: s = main + t1. Integer: round t1 half away from zero.
      pipe_in[1] = pipe_ff[0];
      if (fmt_int) begin
         pipe_in[1].u    = fp_int_round_pre(pipe_ff[0].t1);
         pipe_in[1].ival = fp_int_value(pipe_ff[0].t1);
      end else begin
         pipe_in[1].u    = fp_add_pre(pipe_ff[0].mw, pipe_ff[0].t1, 1'b0);
      end

      // Round s (or r); the main result is final here.
      pipe_in[2]   = pipe_ff[1];
      pipe_in[2].a = fp_round_pack(pipe_ff[1].u);
      pipe_in[2].mo = fmt_int ? (pipe_ff[1].mw + pipe_ff[1].ival) : pipe_in[2].a;

      // Float: d = s - main. Integer: residual t1 - r.
      pipe_in[3] = pipe_ff[2];
      if (fmt_int) begin
         pipe_in[3].u = fp_add_pre(pipe_ff[2].t1, pipe_ff[2].a, 1'b1);
      end else begin
         pipe_in[3].u = fp_add_pre(pipe_ff[2].a, pipe_ff[2].mw, 1'b1);
      end

      pipe_in[4]   = pipe_ff[3];
      pipe_in[4].a = fp_round_pack(pipe_ff[3].u);

      // Float: e = t1 - d. Integer: carry the residual on unchanged.
      pipe_in[5] = pipe_ff[4];
      if (fmt_int) begin
         pipe_in[5].u = fp_scale_pre(pipe_ff[4].a, 6'sd0);
      end else begin
         pipe_in[5].u = fp_add_pre(pipe_ff[4].t1, pipe_ff[4].a, 1'b1);
      end

      pipe_in[6]   = pipe_ff[5];
      pipe_in[6].a = fp_round_pack(pipe_ff[5].u);

      // Scale the residual back up by 2^k.
      pipe_in[7]   = pipe_ff[6];
      pipe_in[7].a = fp_round_pack(fp_scale_pre(pipe_ff[6].a, k_s));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload holds when its stage does not advance.
   always_ff @(posedge clock) begin
      for (int i = 0; i < STAGES; i++) begin
         if (en[i]) begin
            pipe_ff[i] <= pipe_in[i];
         end
      end
   end

   assign rsp_valid      = valid_ff[STAGES-1];
   assign rsp_main_out   = pipe_ff[STAGES-1].mo;
   assign rsp_buffer_out = pipe_ff[STAGES-1].a;
   assign rsp_last_out   = pipe_ff[STAGES-1].last;

   a_ready_when_drained: assert property (@(posedge clock) disable iff (reset)
      !valid_ff[STAGES-1] |-> req_ready)
      else $error("request side stalled with an empty output stage");

   a_accept_fills_first: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> valid_ff[0])
      else $error("accepted beat lost at first stage");

   a_mid_stage_holds: assert property (@(posedge clock) disable iff (reset)
      valid_ff[3] && !en[3] |=> valid_ff[3] && $stable(pipe_ff[3].u))
      else $error("stalled middle stage changed");

   a_special_exclusive: assert property (@(posedge clock) disable iff (reset)
      valid_ff[1] |-> !(pipe_ff[1].u.nan && pipe_ff[1].u.inf))
      else $error("sum flagged both NaN and infinite");

endmodule
`default_nettype wire

// ===== bench/tb_top.sv =====
module tb_top;
   import scwb_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_WAIT  = 12;   // pipeline is 8 deep, allow some slack

   typedef enum {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_mode_type;

   // one write-back beat as it leaves the block
   typedef struct packed {
      logic [31:0] main_val;
      logic [31:0] resid;
      logic        last;
   } wb_beat_type;

   // binary32 operand taken apart: value = m * 2^ex
   typedef struct packed {
      logic               is_nan;
      logic               is_inf;
      logic               sgn;
      logic [23:0]        m;
      logic signed [15:0] ex;
   } f32_parts_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [31:0] req_main_word = '0;
   logic [31:0] req_buffer_word = '0;
   logic        req_last_in = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_main_out;
   logic [31:0] rsp_buffer_out;
   logic        rsp_last_out;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [ADDR_W-1:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   // shadow copy of the block's registers
   logic [3:0]  shadow_shift = 4'd5;
   fmt_type     shadow_fmt = FMT_FLOAT;

   wb_beat_type pending_wb[$];
   int          fail_count = 0;
   int          beats_checked = 0;
   int          settings_used = 1;
   int          cycle_count = 0;
   int          burst_left = 0;
   int          hold_len = 0;
   int          hold_left = 0;
   rx_mode_type rx_mode = RX_ALWAYS;

   single_precision_compensated_writeback DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_main_word(req_main_word), .req_buffer_word(req_buffer_word),
      .req_last_in(req_last_in),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_main_out(rsp_main_out), .rsp_buffer_out(rsp_buffer_out),
      .rsp_last_out(rsp_last_out),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always #5 clock = ~clock;

   // Watchdog: a stuck handshake ends the run here.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d beats still pending",
                  cycle_count, pending_wb.size());
         $display("Test completed with failures");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Binary32 arithmetic, round to nearest even, subnormals kept.
   // Every operation is worked out exactly and rounded once.
   // ------------------------------------------------------------------

   // round sgn * mag * 2^ex to binary32
   function automatic logic [31:0] f32_pack(input logic sgn, input logic [127:0] mag,
                                            input int ex);
      int           p;
      int           lsbx;
      int           sh;
      logic [127:0] mm;
      logic [127:0] rest;
      logic         g;
      logic         st;
      if (mag == '0) return {sgn, 31'd0};
      p = 0;
      for (int i = 0; i < 128; i++) begin
         if (mag[i]) p = i;
      end
      // weight of the last kept bit, floored at the subnormal step
      lsbx = p + ex - 23;
      if (lsbx < -149) lsbx = -149;
      sh = lsbx - ex;
      g  = 1'b0;
      st = 1'b0;
      if (sh >= 129) begin
         mm = '0;
         st = 1'b1;
      end else if (sh > 0) begin
         mm   = mag >> sh;
         g    = mag[sh-1];
         rest = mag & ((128'd1 << (sh - 1)) - 128'd1);
         st   = |rest;
      end else begin
         mm = mag << (-sh);
      end
      if (g && (st || mm[0])) mm = mm + 128'd1;
      if (mm[24]) begin
         mm   = mm >> 1;
         lsbx = lsbx + 1;
      end
      if (!mm[23]) return {sgn, 8'd0, mm[22:0]};
      if (lsbx + 150 >= 255) return {sgn, 8'hFF, 23'd0};
      return {sgn, 8'(lsbx + 150), mm[22:0]};
   endfunction

   function automatic f32_parts_type f32_split(input logic [31:0] f);
      f32_parts_type q;
      q.is_nan = (f[30:23] == 8'hFF) && (f[22:0] != '0);
      q.is_inf = (f[30:23] == 8'hFF) && (f[22:0] == '0);
      q.sgn    = f[31];
      q.m      = {(f[30:23] != 8'd0), f[22:0]};
      q.ex     = (f[30:23] == 8'd0) ? -16'sd149 : 16'(int'(f[30:23]) - 150);
      return q;
   endfunction

   // f * 2^j
   function automatic logic [31:0] f32_scale(input logic [31:0] f, input int j);
      f32_parts_type q;
      q = f32_split(f);
      if (q.is_nan) return QNAN_BITS;
      if (q.is_inf) return {q.sgn, 8'hFF, 23'd0};
      return f32_pack(q.sgn, {104'd0, q.m}, int'(q.ex) + j);
   endfunction

   function automatic logic [31:0] f32_add(input logic [31:0] a, input logic [31:0] b);
      f32_parts_type pa;
      f32_parts_type pb;
      f32_parts_type tmp;
      int            d;
      int            sh;
      logic [127:0]  ma;
      logic [127:0]  mb;
      logic [127:0]  mag;
      logic          sgn;
      pa = f32_split(a);
      pb = f32_split(b);
      if (pa.is_nan || pb.is_nan) return QNAN_BITS;
      if (pa.is_inf && pb.is_inf) return (pa.sgn != pb.sgn) ? QNAN_BITS : a;
      if (pa.is_inf) return {pa.sgn, 8'hFF, 23'd0};
      if (pb.is_inf) return {pb.sgn, 8'hFF, 23'd0};
      // keep the larger exponent in pa
      if (pb.ex > pa.ex) begin
         tmp = pa;
         pa  = pb;
         pb  = tmp;
      end
      d  = int'(pa.ex) - int'(pb.ex);
      ma = {104'd0, pa.m} << 40;
      if (d <= 40) begin
         mb = {104'd0, pb.m} << (40 - d);
      end else begin
         // far below the rounding point: keep a sticky bit only
         sh = d - 40;
         if (sh >= 24) mb = {127'd0, (pb.m != '0)};
         else mb = ({104'd0, pb.m} >> sh)
                   | {127'd0, |(pb.m & ((24'd1 << sh) - 24'd1))};
      end
      if (pa.sgn == pb.sgn) begin
         mag = ma + mb;
         sgn = pa.sgn;
      end else if (ma >= mb) begin
         mag = ma - mb;
         sgn = pa.sgn;
      end else begin
         mag = mb - ma;
         sgn = pb.sgn;
      end
      // exact zero: signed only when both operands share the sign
      if (mag == '0) sgn = (pa.sgn == pb.sgn) ? pa.sgn : 1'b0;
      return f32_pack(sgn, mag, int'(pa.ex) - 40);
   endfunction

   function automatic logic [31:0] f32_neg(input logic [31:0] f);
      return {~f[31], f[30:0]};
   endfunction

   // Expected write-back of one element pair under the shadow registers.
   function automatic wb_beat_type predict_writeback(input logic [31:0] mw,
                                                     input logic [31:0] bw, input logic l);
      wb_beat_type   w;
      f32_parts_type pt;
      logic [31:0]   t1;
      logic [31:0]   s;
      logic [31:0]   dd;
      logic [31:0]   err;
      logic [31:0]   r;
      logic [31:0]   ival;
      logic [127:0]  mag;
      int            k;
      int            sh;
      k  = int'(shadow_shift);
      t1 = f32_scale(bw, -k);
      w.last = l;
      if (shadow_fmt == FMT_FLOAT) begin
         // fast two-sum: the low part that the add dropped goes back to the buffer
         s   = f32_add(mw, t1);
         dd  = f32_add(s, f32_neg(mw));
         err = f32_add(t1, f32_neg(dd));
         w.main_val = s;
         w.resid    = f32_scale(err, k);
      end else begin
         pt = f32_split(t1);
         if (pt.is_nan) begin
            r    = QNAN_BITS;
            ival = 32'd0;
         end else if (pt.is_inf || t1[30:23] >= 8'd158) begin
            r    = t1;
            ival = t1[31] ? 32'h8000_0000 : 32'h7FFF_FFFF;
         end else if (t1[30:23] >= 8'd150) begin
            // already integral
            r   = t1;
            mag = {104'd0, pt.m} << (int'(pt.ex));
            ival = t1[31] ? (32'd0 - mag[31:0]) : mag[31:0];
         end else begin
            // round half away from zero, a zero keeps the sign of t1
            sh = -int'(pt.ex);
            if (sh > 24) mag = '0;
            else mag = ({104'd0, pt.m} >> sh) + {127'd0, pt.m[sh-1]};
            r    = (mag == '0) ? {t1[31], 31'd0} : f32_pack(t1[31], mag, 0);
            ival = t1[31] ? (32'd0 - mag[31:0]) : mag[31:0];
         end
         w.main_val = mw + ival;
         w.resid    = f32_scale(f32_add(t1, f32_neg(r)), k);
      end
      return w;
   endfunction

   // ------------------------------------------------------------------
   // Result side: receiver stalls and the scoreboard.
   // ------------------------------------------------------------------

   // Drive rsp_ready; a requested hold-off is counted down here.
   always @(posedge clock) begin
      if (hold_len > 0) begin
         hold_left = hold_len;
         hold_len  = 0;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         case (rx_mode)
            RX_ALWAYS:  rsp_ready <= 1'b1;
            RX_RANDOM:  rsp_ready <= ($urandom_range(0, 3) != 0);
            RX_PATTERN: rsp_ready <= ((cycle_count % 7) < 4);
            default:    rsp_ready <= 1'b1;
         endcase
      end
   end

   // Compare every accepted result beat with the oldest expectation.
   always @(posedge clock) begin
      wb_beat_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_wb.size() == 0) begin
            $display("%0t: result beat with nothing expected: main %h buffer %h last %b",
                     $time, rsp_main_out, rsp_buffer_out, rsp_last_out);
            fail_count++;
         end else begin
            want = pending_wb.pop_front();
            beats_checked++;
            if (rsp_main_out !== want.main_val) begin
               $display("%0t: main_out expected %h actual %h",
                        $time, want.main_val, rsp_main_out);
               fail_count++;
            end
            if (rsp_buffer_out !== want.resid) begin
               $display("%0t: buffer_out expected %h actual %h",
                        $time, want.resid, rsp_buffer_out);
               fail_count++;
            end
            if (rsp_last_out !== want.last) begin
               $display("%0t: last_out expected %b actual %b",
                        $time, want.last, rsp_last_out);
               fail_count++;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------

   // APB write: setup cycle, access cycle, then release the bus.
   task automatic csr_write(input reg_idx_type idx, input logic [31:0] val);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= val;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (idx == REG_SCALE_SHIFT) shadow_shift = val[3:0];
      else shadow_fmt = fmt_type'(val[0]);
      @(posedge clock);
   endtask

   // Offer one element pair and hold it until the block takes the beat.
   task automatic send_pair(input logic [31:0] mw, input logic [31:0] bw, input logic l);
      req_valid       <= 1'b1;
      req_main_word   <= mw;
      req_buffer_word <= bw;
      req_last_in     <= l;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_wb.push_back(predict_writeback(mw, bw, l));
   endtask

   // Bursts of random length with random gaps between them.
   task automatic send_bursty(input logic [31:0] mw, input logic [31:0] bw, input logic l);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      send_pair(mw, bw, l);
   endtask

   // Drop valid, wait until every expected beat is back, then let the pipe settle.
   task automatic drain_all;
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_wb.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic apply_setting(input logic [3:0] k, input fmt_type fmt);
      drain_all();
      csr_write(REG_SCALE_SHIFT, {28'd0, k});
      csr_write(REG_NUMBER_FORMAT, {31'd0, fmt});
      settings_used++;
   endtask

   function automatic logic [31:0] pick_float;
      logic [31:0] special[10];
      special = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
                  32'h7FC0_0000, 32'h7F80_0001, 32'h7F7F_FFFF, 32'h0000_0001,
                  32'h007F_FFFF, 32'hFFFF_FFFF};
      case ($urandom_range(0, 9))
         0:       return special[$urandom_range(0, 9)];
         1:       return {1'($urandom), 8'd0, 23'($urandom)};
         2, 3:    return $urandom;
         default: return {1'($urandom), 8'($urandom_range(100, 160)), 23'($urandom)};
      endcase
   endfunction

   // Buffer word whose scaled value is useful for the current mode.
   function automatic logic [31:0] pick_buffer(input logic [31:0] mw);
      int xe;
      int k;
      k = int'(shadow_shift);
      if (shadow_fmt == FMT_FLOAT) begin
         if ($urandom_range(0, 9) < 6 && mw[30:23] != 8'hFF && mw[30:23] != 8'd0) begin
            // a little below the main value, so the two-sum leaves a residual
            xe = int'(mw[30:23]) + k - $urandom_range(0, 30);
            if (xe < 1) xe = 1;
            if (xe > 254) xe = 254;
            return {1'($urandom), 8'(xe), 23'($urandom)};
         end
         return pick_float();
      end
      case ($urandom_range(0, 9))
         0, 1, 2: return f32_pack(1'($urandom), 128'($urandom_range(0, 2000) * 2 + 1), k - 1);
         3, 4:    return {1'($urandom), 8'($urandom_range(115, 150 + k)), 23'($urandom)};
         default: return pick_float();
      endcase
   endfunction

   function automatic logic [31:0] pick_main;
      if (shadow_fmt == FMT_FLOAT) return pick_float();
      case ($urandom_range(0, 7))
         0:       return 32'h7FFF_FFFF;
         1:       return 32'h8000_0000;
         2:       return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Reset settings (shift 5, float): zeros, extremes, NaN, infinities, overflow.
   task automatic test_float_corners;
      send_pair(32'h3F80_0000, 32'h0000_0000, 1'b0);
      send_pair(32'h3F80_0000, 32'h3F80_0000, 1'b1);
      send_pair(32'h3F80_0000, 32'h3380_0000, 1'b0);   // drops below the ulp
      send_pair(32'h4B80_0000, 32'h3F80_0000, 1'b0);
      send_pair(32'h0000_0000, 32'h8000_0000, 1'b0);
      send_pair(32'h8000_0000, 32'h8000_0000, 1'b1);
      send_pair(32'h7F7F_FFFF, 32'h7F7F_FFFF, 1'b0);   // overflow to infinity
      send_pair(32'h7F80_0000, 32'hFF80_0000, 1'b0);   // inf - inf
      send_pair(32'h7FC0_0000, 32'h3F80_0000, 1'b0);
      send_pair(32'h7F80_0001, 32'h0000_0000, 1'b1);   // signalling NaN comes out quiet
      send_pair(32'h0000_0001, 32'h8000_0001, 1'b0);
      send_pair(32'h007F_FFFF, 32'h0000_0001, 1'b0);
      send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
   endtask

   // Integer mode at shift 1: ties, signed zeros, saturation, wrap, NaN and inf.
   task automatic test_int_corners;
      apply_setting(4'd1, FMT_INT);
      send_pair(32'd10, 32'h3F80_0000, 1'b0);          // +0.5 rounds to +1
      send_pair(32'd10, 32'hBF80_0000, 1'b0);          // -0.5 rounds to -1
      send_pair(32'd0, 32'h4040_0000, 1'b0);           // 1.5
      send_pair(32'd0, 32'hC040_0000, 1'b1);           // -1.5
      send_pair(32'd0, 32'h40A0_0000, 1'b0);           // 2.5 goes away from zero
      send_pair(32'd7, 32'h3F00_0000, 1'b0);           // +0.25 gives +0
      send_pair(32'd7, 32'hBF00_0000, 1'b0);           // -0.25 gives -0
      send_pair(32'd1, 32'h4F80_0000, 1'b1);           // saturates high
      send_pair(32'd1, 32'hCF80_0000, 1'b0);           // saturates low
      send_pair(32'd5, 32'h7F80_0000, 1'b0);           // inf: residual is NaN
      send_pair(32'd5, 32'h7FC0_0000, 1'b0);           // NaN leaves main alone
      send_pair(32'h7FFF_FFFF, 32'h4000_0000, 1'b1);   // wraps
      send_pair(32'h8000_0000, 32'hC000_0000, 1'b0);
      send_pair(32'hFFFF_FFFF, 32'h0000_0000, 1'b1);
   endtask

   task automatic test_random_phase(input logic [3:0] k, input fmt_type fmt, input int n);
      logic [31:0] mw;
      apply_setting(k, fmt);
      rx_mode = rx_mode_type'($urandom_range(0, 2));
      for (int i = 0; i < n; i++) begin
         mw = pick_main();
         send_bursty(mw, pick_buffer(mw), ($urandom_range(0, 7) == 0));
      end
   endtask

   // Hold the receiver off while the sender keeps offering beats back to back.
   task automatic test_backpressure;
      logic [31:0] mw;
      apply_setting(4'd9, FMT_FLOAT);
      rx_mode  = RX_ALWAYS;
      hold_len = 80;
      for (int i = 0; i < 60; i++) begin
         mw = pick_main();
         send_pair(mw, pick_buffer(mw), i[0]);
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_float_corners();
      test_int_corners();
      test_random_phase(4'd0, FMT_FLOAT, 200);
      test_random_phase(4'd15, FMT_FLOAT, 200);
      test_backpressure();
      test_random_phase(4'd0, FMT_INT, 200);
      test_random_phase(4'd15, FMT_INT, 200);
      test_random_phase(4'($urandom), FMT_FLOAT, 150);
      test_random_phase(4'($urandom), FMT_INT, 150);
      drain_all();
      $display("Checked %0d write-back beats over %0d register settings,", beats_checked,
               settings_used);
      $display("float two-sum and integer rounding, shifts 0 to 15, with stalls and gaps.");
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
